// ===== src/sprq_pkg.sv =====
// Shared constants and types for the sprite part quad setup unit.
package sprq_pkg;

  // Default number of fraction bits in the scale factor
  localparam int FRACTION_BITS_DEF = 12;

  // Datapath widths
  localparam int COORD_W    = 16;
  localparam int TEXC_W     = 8;
  localparam int PROD_W     = 34;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MODE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BASE_X = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BASE_Y = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SCALE  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_FLIP_X = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_FLIP_Y = 3'd5;

  // Mode codes
  localparam logic MODE_PLAIN   = 1'b0;
  localparam logic MODE_FLIPPED = 1'b1;

  // Scale after reset: unity at twelve fraction bits
  localparam logic [COORD_W-1:0] SCALE_RESET = 16'd4096;

  // Load enables for the two stages of a scale unit
  typedef struct packed {
    logic mul_en;
    logic trunc_en;
  } sprq_stage_en_t;

endpackage

// ===== src/sprq_scale_term.sv =====
// Two-stage scale unit: signed term times scale, truncated toward zero.
module sprq_scale_term #(
  parameter int FRACTION_BITS = sprq_pkg::FRACTION_BITS_DEF
) (
  input  logic                           clk,
  input  sprq_pkg::sprq_stage_en_t       en,
  input  logic [sprq_pkg::COORD_W-1:0]   raw,
  input  logic [sprq_pkg::COORD_W-1:0]   scale,
  output logic [sprq_pkg::COORD_W-1:0]   term
);

  localparam int PW = sprq_pkg::PROD_W;
  localparam int CW = sprq_pkg::COORD_W;
  localparam logic [PW-1:0] RND_MASK = {{(PW-FRACTION_BITS){1'b0}}, {FRACTION_BITS{1'b1}}};

  logic signed [PW-1:0] prod_r;
  logic signed [PW-1:0] prod_nxt;
  logic        [PW-1:0] biased;
  logic        [CW-1:0] term_r;
  logic        [CW-1:0] term_nxt;

  // Multiply the sign-extended term by the unsigned scale
  assign prod_nxt = $signed({raw[CW-1], raw}) * $signed({1'b0, scale});

  always_ff @(posedge clk) begin
    if (en.mul_en) begin
      prod_r <= prod_nxt;
    end
  end

  // Bias negative products so the shift rounds toward zero
  assign biased   = prod_r + (prod_r[PW-1] ? RND_MASK : '0);
  assign term_nxt = biased[FRACTION_BITS+CW-1:FRACTION_BITS];

  always_ff @(posedge clk) begin
    if (en.trunc_en) begin
      term_r <= term_nxt;
    end
  end

  assign term = term_r;

endmodule

// ===== src/sprite_part_quad_setup_unit.sv =====
// Sprite part quad setup: five-stage pipeline from part record to quad description.
// Five register stages lie between an input transfer and its result on out_*.
// Throughput: one item per cycle while out_stall is low; each stage holds its item while the next cannot take it.
// The scale multipliers (17x17) sit in stage one with truncation in stage two.
// Reset (rst_n low, synchronous) empties every stage and loads the register defaults.
module sprite_part_quad_setup_unit #(
  parameter int FRACTION_BITS = sprq_pkg::FRACTION_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // configuration port
  input  logic                              cfg_we,
  input  logic [sprq_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [sprq_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  // input channel
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [15:0]                       in_tex_u,
  input  logic [15:0]                       in_tex_v,
  input  logic [15:0]                       in_tex_w,
  input  logic [15:0]                       in_tex_h,
  input  logic signed [15:0]                in_offset_x,
  input  logic signed [15:0]                in_offset_y,
  input  logic [1:0]                        in_page_depth,
  input  logic [9:0]                        in_palette_x,
  input  logic [8:0]                        in_palette_y,
  input  logic [9:0]                        in_page_x,
  input  logic [8:0]                        in_page_y,
  input  logic [1:0]                        in_mirror,
  // result channel
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [15:0]                out_x_left,
  output logic signed [15:0]                out_x_right,
  output logic signed [15:0]                out_y_top,
  output logic signed [15:0]                out_y_bottom,
  output logic [7:0]                        out_u_first,
  output logic [7:0]                        out_u_second,
  output logic [7:0]                        out_v_first,
  output logic [7:0]                        out_v_second,
  output logic [15:0]                       out_palette_word,
  output logic [15:0]                       out_page_word
);

  localparam int CW = sprq_pkg::COORD_W;
  localparam int TW = sprq_pkg::TEXC_W;

  // Configuration registers
  logic          mode_r;
  logic [CW-1:0] base_x_r;
  logic [CW-1:0] base_y_r;
  logic [CW-1:0] scale_r;
  logic          flip_x_r;
  logic          flip_y_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= sprq_pkg::MODE_PLAIN;
      base_x_r <= '0;
      base_y_r <= '0;
      scale_r  <= sprq_pkg::SCALE_RESET;
      flip_x_r <= 1'b0;
      flip_y_r <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        sprq_pkg::CFG_MODE:   mode_r   <= cfg_wdata[0];
        sprq_pkg::CFG_BASE_X: base_x_r <= cfg_wdata;
        sprq_pkg::CFG_BASE_Y: base_y_r <= cfg_wdata;
        sprq_pkg::CFG_SCALE:  scale_r  <= cfg_wdata;
        sprq_pkg::CFG_FLIP_X: flip_x_r <= cfg_wdata[0];
        sprq_pkg::CFG_FLIP_Y: flip_y_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  logic flipped;
  logic neg_x;
  logic neg_y;

  assign flipped = (mode_r == sprq_pkg::MODE_FLIPPED);
  assign neg_x   = flipped && flip_x_r;
  assign neg_y   = flipped && flip_y_r;

  // Stage valids and ready chain
  logic v1_r, v2_r, v3_r, v4_r, v5_r;
  logic rdy1, rdy2, rdy3, rdy4, rdy5;

  assign rdy5     = !v5_r || !out_stall;
  assign rdy4     = !v4_r || rdy5;
  assign rdy3     = !v3_r || rdy4;
  assign rdy2     = !v2_r || rdy3;
  assign rdy1     = !v1_r || rdy2;
  assign in_stall = !rdy1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= in_valid;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
      if (rdy4) v4_r <= v3_r;
      if (rdy5) v5_r <= v4_r;
    end
  end

  // Scale units: multiply in stage one, truncate in stage two
  sprq_pkg::sprq_stage_en_t scale_en;
  logic [CW-1:0] left2, top2, width2, height2;

  assign scale_en.mul_en   = rdy1;
  assign scale_en.trunc_en = rdy2;

  sprq_scale_term #(.FRACTION_BITS(FRACTION_BITS)) u_scale_ox (
    .clk(clk), .en(scale_en), .raw(in_offset_x), .scale(scale_r), .term(left2)
  );
  sprq_scale_term #(.FRACTION_BITS(FRACTION_BITS)) u_scale_oy (
    .clk(clk), .en(scale_en), .raw(in_offset_y), .scale(scale_r), .term(top2)
  );
  sprq_scale_term #(.FRACTION_BITS(FRACTION_BITS)) u_scale_w (
    .clk(clk), .en(scale_en), .raw(in_tex_w), .scale(scale_r), .term(width2)
  );
  sprq_scale_term #(.FRACTION_BITS(FRACTION_BITS)) u_scale_h (
    .clk(clk), .en(scale_en), .raw(in_tex_h), .scale(scale_r), .term(height2)
  );

  // Stage one: capture texture fields and form the palette and page words
  logic [CW-1:0] u1_r, v1d_r, u2_r, v2d_r;
  logic [TW-1:0] w1_r, h1_r, w2_r, h2_r;
  logic [1:0]    mir1_r, mir2_r, mir3_r, mir4_r;
  logic [15:0]   pal1_r, pal2_r, pal3_r, pal4_r;
  logic [15:0]   page1_r, page2_r, page3_r, page4_r;
  logic [15:0]   pal_nxt, page_nxt;

  assign pal_nxt  = {1'b0, in_palette_y, in_palette_x[9:4]};
  assign page_nxt = {7'b0, in_page_depth, 2'b0, in_page_y[8], in_page_x[9:6]};

  always_ff @(posedge clk) begin
    if (rdy1) begin
      u1_r    <= in_tex_u;
      v1d_r   <= in_tex_v;
      w1_r    <= in_tex_w[TW-1:0];
      h1_r    <= in_tex_h[TW-1:0];
      mir1_r  <= in_mirror;
      pal1_r  <= pal_nxt;
      page1_r <= page_nxt;
    end
  end

  // Stage two: carry side fields alongside truncation
  always_ff @(posedge clk) begin
    if (rdy2) begin
      u2_r    <= u1_r;
      v2d_r   <= v1d_r;
      w2_r    <= w1_r;
      h2_r    <= h1_r;
      mir2_r  <= mir1_r;
      pal2_r  <= pal1_r;
      page2_r <= page1_r;
    end
  end

  // Stage three: near edges, signed sizes and both texture candidates
  logic [CW-1:0] near_x3_r, near_y3_r, size_x3_r, size_y3_r;
  logic [CW-1:0] near_x_nxt, near_y_nxt, size_x_nxt, size_y_nxt;
  logic [CW-1:0] u_m1, v_m1;
  logic [TW-1:0] us_first, vs_first, ws, hs;
  logic [TW-1:0] uk_f3_r, uk_s3_r, us_f3_r, us_s3_r;
  logic [TW-1:0] vk_f3_r, vk_s3_r, vs_f3_r, vs_s3_r;

  assign near_x_nxt = neg_x ? (base_x_r - left2) : (base_x_r + left2);
  assign near_y_nxt = neg_y ? (base_y_r - top2)  : (base_y_r + top2);
  assign size_x_nxt = neg_x ? (CW'(0) - width2)  : width2;
  assign size_y_nxt = neg_y ? (CW'(0) - height2) : height2;

  // Step back one texel, clamping at zero and shrinking the extent
  assign u_m1     = u2_r - CW'(1);
  assign v_m1     = v2d_r - CW'(1);
  assign us_first = u_m1[CW-1] ? '0 : u_m1[TW-1:0];
  assign vs_first = v_m1[CW-1] ? '0 : v_m1[TW-1:0];
  assign ws       = u_m1[CW-1] ? (w2_r - TW'(1)) : w2_r;
  assign hs       = v_m1[CW-1] ? (h2_r - TW'(1)) : h2_r;

  always_ff @(posedge clk) begin
    if (rdy3) begin
      near_x3_r <= near_x_nxt;
      near_y3_r <= near_y_nxt;
      size_x3_r <= size_x_nxt;
      size_y3_r <= size_y_nxt;
      uk_f3_r   <= u2_r[TW-1:0];
      uk_s3_r   <= u2_r[TW-1:0] + w2_r;
      us_f3_r   <= us_first;
      us_s3_r   <= us_first + ws;
      vk_f3_r   <= v2d_r[TW-1:0];
      vk_s3_r   <= v2d_r[TW-1:0] + h2_r;
      vs_f3_r   <= vs_first;
      vs_s3_r   <= vs_first + hs;
      mir3_r    <= mir2_r;
      pal3_r    <= pal2_r;
      page3_r   <= page2_r;
    end
  end

  // Stage four: far edges and mirror swap
  logic [CW-1:0] far_x, far_y;
  logic [CW-1:0] xl4_r, xr4_r, yt4_r, yb4_r;
  logic [TW-1:0] uk_f4_r, uk_s4_r, us_f4_r, us_s4_r;
  logic [TW-1:0] vk_f4_r, vk_s4_r, vs_f4_r, vs_s4_r;

  assign far_x = near_x3_r + size_x3_r;
  assign far_y = near_y3_r + size_y3_r;

  always_ff @(posedge clk) begin
    if (rdy4) begin
      xl4_r   <= mir3_r[0] ? far_x : near_x3_r;
      xr4_r   <= mir3_r[0] ? near_x3_r : far_x;
      yt4_r   <= mir3_r[1] ? far_y : near_y3_r;
      yb4_r   <= mir3_r[1] ? near_y3_r : far_y;
      uk_f4_r <= uk_f3_r;
      uk_s4_r <= uk_s3_r;
      us_f4_r <= us_f3_r;
      us_s4_r <= us_s3_r;
      vk_f4_r <= vk_f3_r;
      vk_s4_r <= vk_s3_r;
      vs_f4_r <= vs_f3_r;
      vs_s4_r <= vs_s3_r;
      mir4_r  <= mir3_r;
      pal4_r  <= pal3_r;
      page4_r <= page3_r;
    end
  end

  // Stage five: decide the step back per axis and register the result
  logic step_u, step_v;
  logic [CW-1:0] xl5_r, xr5_r, yt5_r, yb5_r;
  logic [TW-1:0] uf5_r, us5_r, vf5_r, vs5_r;
  logic [15:0]   pal5_r, page5_r;

  assign step_u = flipped ? ($signed(xr4_r) < $signed(xl4_r)) : mir4_r[0];
  assign step_v = flipped ? ($signed(yb4_r) < $signed(yt4_r)) : mir4_r[1];

  always_ff @(posedge clk) begin
    if (rdy5) begin
      xl5_r   <= xl4_r;
      xr5_r   <= xr4_r;
      yt5_r   <= yt4_r;
      yb5_r   <= yb4_r;
      uf5_r   <= step_u ? us_f4_r : uk_f4_r;
      us5_r   <= step_u ? us_s4_r : uk_s4_r;
      vf5_r   <= step_v ? vs_f4_r : vk_f4_r;
      vs5_r   <= step_v ? vs_s4_r : vk_s4_r;
      pal5_r  <= pal4_r;
      page5_r <= page4_r;
    end
  end

  assign out_valid        = v5_r;
  assign out_x_left       = xl5_r;
  assign out_x_right      = xr5_r;
  assign out_y_top        = yt5_r;
  assign out_y_bottom     = yb5_r;
  assign out_u_first      = uf5_r;
  assign out_u_second     = us5_r;
  assign out_v_first      = vf5_r;
  assign out_v_second     = vs5_r;
  assign out_palette_word = pal5_r;
  assign out_page_word    = page5_r;

  // Input is held back only when every stage is full and the output is stalled
  assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (v1_r && v2_r && v3_r && v4_r && v5_r && out_stall))
    else $error("input stalled while the pipeline has a free stage");

  // Stage four, when it cannot advance, keeps its item and its edge values
  assert property (@(posedge clk) disable iff (!rst_n)
    (v4_r && !rdy4) |=> (v4_r && $stable(xl4_r) && $stable(xr4_r)))
    else $error("stage four item lost or changed while held");

  // The pipeline comes out of reset empty
  assert property (@(posedge clk)
    $past(!rst_n) |-> (!v1_r && !v2_r && !v3_r && !v4_r && !v5_r))
    else $error("stage valid set straight after reset");

endmodule
